FILE: rtl/sky_gradient_pixel_generator_defines.svh
// Assertion macros used by the sky gradient RTL.
`ifndef SKY_GRADIENT_PIXEL_GENERATOR_DEFINES_SVH
`define SKY_GRADIENT_PIXEL_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define SGPG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define SGPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sgpg_pkg.sv
// Package with constants, types and helper functions of the sky gradient generator.
`timescale 1ns / 1ps
package sgpg_pkg;

   localparam int MAX_DIM    = 4096;
   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = $clog2(MAX_DIM);
   localparam int DIM_W      = COORD_W + 1;
   localparam int OFFSET_W   = 26;
   localparam int V_W        = FRAC_BITS + 1;
   localparam int CH_W       = 8;
   localparam int SAT_W      = CH_W + 1;
   localparam int DIM_RESET  = 256;

   // gradient divider: one quotient bit per step
   localparam int DIV_STEPS  = V_W;
   localparam int DIV_SPS    = 3;
   localparam int DIV_STAGES = (DIV_STEPS + DIV_SPS - 1) / DIV_SPS;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_BACKGROUND = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_SKY        = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_WIDTH      = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_HEIGHT     = 2'd3;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic                in_frame;
      logic                last;
   } side_type;

   typedef struct packed {
      logic [CH_W-1:0] base_r;
      logic [CH_W-1:0] base_g;
      logic [CH_W-1:0] base_b;
      logic [CH_W-1:0] bg_r;
      logic [CH_W-1:0] bg_g;
      logic [CH_W-1:0] bg_b;
      logic [CH_W-1:0] sky_a;
   } shade_cfg_type;

   // one restoring division step: returns {quotient bit, new remainder}
   function automatic logic [COORD_W:0] div_step(input logic [COORD_W-1:0] rem,
                                                 input logic               nb,
                                                 input logic [COORD_W-1:0] dvs);
      logic [COORD_W:0] trial;
      logic [COORD_W:0] diff;
      trial = {rem, nb};
      diff  = trial - {1'b0, dvs};
      if (trial >= {1'b0, dvs}) begin
         return {1'b1, diff[COORD_W-1:0]};
      end else begin
         return {1'b0, trial[COORD_W-1:0]};
      end
   endfunction

   function automatic logic [CH_W-1:0] sat8(input logic [SAT_W-1:0] val);
      return val[SAT_W-1] ? {CH_W{1'b1}} : val[CH_W-1:0];
   endfunction

endpackage

FILE: rtl/sgpg_div.sv
// Pipelined restoring divider giving the gradient position v = (row << 16) / (H - 1).
`timescale 1ns / 1ps
module sgpg_div import sgpg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [COORD_W-1:0] in_row,
   input  side_type           in_side,
   input  logic [COORD_W-1:0] dvs,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [V_W-1:0]     out_v,
   output side_type           out_side
);

   logic               vld_ff  [DIV_STAGES];
   logic [COORD_W-1:0] rem_ff  [DIV_STAGES];
   logic [V_W-1:0]     quo_ff  [DIV_STAGES];
   side_type           side_ff [DIV_STAGES];
   logic               adv     [DIV_STAGES+1];

   assign adv[DIV_STAGES] = out_ready;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic               vld_in;
      logic [COORD_W-1:0] src_rem;
      logic [V_W-1:0]     src_quo;
      logic               src_bit;
      side_type           src_side;
      logic [COORD_W-1:0] rem_in;
      logic [V_W-1:0]     quo_in;
      logic [COORD_W:0]   step_q;

      // start from row >> 1 so the row's low bit is the first one shifted in
      if (k == 0) begin : g_first
         assign vld_in   = in_valid;
         assign src_rem  = {1'b0, in_row[COORD_W-1:1]};
         assign src_quo  = '0;
         assign src_bit  = in_row[0];
         assign src_side = in_side;
      end else begin : g_next
         assign vld_in   = vld_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_quo  = quo_ff[k-1];
         assign src_bit  = 1'b0;
         assign src_side = side_ff[k-1];
      end

      assign adv[k] = !vld_ff[k] || adv[k+1];

      always_comb begin
         rem_in = src_rem;
         quo_in = src_quo;
         step_q = '0;
         for (int j = 0; j < DIV_SPS; j++) begin
            if (k * DIV_SPS + j < DIV_STEPS) begin
               step_q = div_step(rem_in, (j == 0) ? src_bit : 1'b0, dvs);
               rem_in = step_q[COORD_W-1:0];
               quo_in = {quo_in[V_W-2:0], step_q[COORD_W]};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            vld_ff[k] <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= src_side;
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_v     = quo_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

FILE: rtl/sgpg_shade.sv
// Five-stage multiply pipeline: square, alpha scale, blend and premultiply.
`timescale 1ns / 1ps
module sgpg_shade import sgpg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [V_W-1:0]  in_v,
   input  side_type        in_side,
   input  shade_cfg_type   cfg,
   output logic            out_valid,
   input  logic            out_ready,
   output logic [CH_W-1:0] out_red,
   output logic [CH_W-1:0] out_green,
   output logic [CH_W-1:0] out_blue,
   output logic [CH_W-1:0] out_alpha,
   output side_type        out_side
);

   localparam int SH_STAGES = 5;
   localparam int PA_W      = V_W + CH_W;
   localparam int RCP_W     = 17;
   localparam int RCP_SHIFT = 24;
   localparam int Q_W       = PA_W + RCP_W;
   localparam int MIX_W     = FRAC_BITS + CH_W;
   localparam int PROD_W    = MIX_W + V_W;
   localparam logic [RCP_W-1:0] RCP255  = 17'h10101;
   localparam logic [CH_W-1:0]  CH_MAX  = 8'hFF;
   localparam logic [V_W-1:0]   FIX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic vld_ff [SH_STAGES];
   logic adv    [SH_STAGES+1];

   assign adv[SH_STAGES] = out_ready;

   for (genvar k = 0; k < SH_STAGES; k++) begin : g_ctl
      logic vld_in;
      if (k == 0) begin : g_first
         assign vld_in = in_valid;
      end else begin : g_next
         assign vld_in = vld_ff[k-1];
      end
      assign adv[k] = !vld_ff[k] || adv[k+1];
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            vld_ff[k] <= vld_in;
         end
      end
   end

   // stage 1: t = v*v, v*sky alpha
   logic [2*V_W-1:0] vv;
   logic [V_W-1:0]   t1_in, t1_ff;
   logic [PA_W-1:0]  pa1_in, pa1_ff;
   side_type         side1_ff;

   assign vv     = (2*V_W)'(in_v) * (2*V_W)'(in_v);
   assign t1_in  = vv[FRAC_BITS +: V_W];
   assign pa1_in = PA_W'(in_v) * PA_W'(cfg.sky_a);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         t1_ff    <= t1_in;
         pa1_ff   <= pa1_in;
         side1_ff <= in_side;
      end
   end

   // stage 2: estimate of (v*sa)/255 through the reciprocal, at most one low
   logic [Q_W-1:0]  qp;
   logic [V_W-1:0]  q2_in, q2_ff;
   logic [V_W-1:0]  t2_ff;
   logic [PA_W-1:0] pa2_ff;
   side_type        side2_ff;

   assign qp    = Q_W'(pa1_ff) * Q_W'(RCP255);
   assign q2_in = qp[RCP_SHIFT +: V_W];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         t2_ff    <= t1_ff;
         pa2_ff   <= pa1_ff;
         q2_ff    <= q2_in;
         side2_ff <= side1_ff;
      end
   end

   // stage 3: correct the quotient, form 1 - t
   logic [PA_W-1:0] rem3;
   logic [V_W-1:0]  a3_in, a3_ff;
   logic [V_W-1:0]  omt3_in, omt3_ff;
   logic [V_W-1:0]  t3_ff;
   side_type        side3_ff;

   assign rem3    = pa2_ff - PA_W'(q2_ff) * PA_W'(CH_MAX);
   assign a3_in   = (rem3 >= PA_W'(CH_MAX)) ? q2_ff + V_W'(1) : q2_ff;
   assign omt3_in = FIX_ONE - t2_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         t3_ff    <= t2_ff;
         omt3_ff  <= omt3_in;
         a3_ff    <= a3_in;
         side3_ff <= side2_ff;
      end
   end

   // stage 4: blend base and background, alpha = 255*a
   logic [PA_W-1:0]  mixr, mixg, mixb, alp;
   logic [MIX_W-1:0] mixr4_ff, mixg4_ff, mixb4_ff;
   logic [V_W-1:0]   a4_ff;
   logic [CH_W-1:0]  alpha4_in, alpha4_ff;
   side_type         side4_ff;

   assign mixr = PA_W'(omt3_ff) * PA_W'(cfg.base_r) + PA_W'(t3_ff) * PA_W'(cfg.bg_r);
   assign mixg = PA_W'(omt3_ff) * PA_W'(cfg.base_g) + PA_W'(t3_ff) * PA_W'(cfg.bg_g);
   assign mixb = PA_W'(omt3_ff) * PA_W'(cfg.base_b) + PA_W'(t3_ff) * PA_W'(cfg.bg_b);
   assign alp  = PA_W'(a3_ff) * PA_W'(CH_MAX);
   assign alpha4_in = sat8(alp[FRAC_BITS +: SAT_W]);

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         mixr4_ff  <= mixr[MIX_W-1:0];
         mixg4_ff  <= mixg[MIX_W-1:0];
         mixb4_ff  <= mixb[MIX_W-1:0];
         a4_ff     <= a3_ff;
         alpha4_ff <= alpha4_in;
         side4_ff  <= side3_ff;
      end
   end

   // stage 5: premultiply by a, outside pixels go black
   logic [PROD_W-1:0] prodr, prodg, prodb;
   logic [CH_W-1:0]   red5_in, green5_in, blue5_in, alpha5_in;
   logic [CH_W-1:0]   red5_ff, green5_ff, blue5_ff, alpha5_ff;
   side_type          side5_ff;

   assign prodr = PROD_W'(mixr4_ff) * PROD_W'(a4_ff);
   assign prodg = PROD_W'(mixg4_ff) * PROD_W'(a4_ff);
   assign prodb = PROD_W'(mixb4_ff) * PROD_W'(a4_ff);

   always_comb begin
      if (side4_ff.in_frame) begin
         red5_in   = sat8(prodr[2*FRAC_BITS +: SAT_W]);
         green5_in = sat8(prodg[2*FRAC_BITS +: SAT_W]);
         blue5_in  = sat8(prodb[2*FRAC_BITS +: SAT_W]);
         alpha5_in = alpha4_ff;
      end else begin
         red5_in   = '0;
         green5_in = '0;
         blue5_in  = '0;
         alpha5_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         red5_ff   <= red5_in;
         green5_ff <= green5_in;
         blue5_ff  <= blue5_in;
         alpha5_ff <= alpha5_in;
         side5_ff  <= side4_ff;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[SH_STAGES-1];
   assign out_red   = red5_ff;
   assign out_green = green5_ff;
   assign out_blue  = blue5_ff;
   assign out_alpha = alpha5_ff;
   assign out_side  = side5_ff;

endmodule

FILE: rtl/sky_gradient_pixel_generator.sv
// Sky gradient pixel generator: one pixel coordinate in, one premultiplied RGBA
// beat out. The block takes one beat per clock while the response side is not
// stalled and holds up to twelve pixels in flight, in one entry register, six
// stages of the 17-bit row divider (three quotient bits in each of the first
// five, two in the last) and five multiplier stages. Every stage holds or
// passes on its own, so a stalled result only stops the stages behind it that
// are full. Registers are written over the APB port (0x0 background, 0x4 sky,
// 0x8 width, 0xC height) and may be changed only while no pixel is in flight;
// the new values apply to the next pixel taken. Width and height above 4096
// act as 4096.
`timescale 1ns / 1ps
`include "sky_gradient_pixel_generator_defines.svh"
module sky_gradient_pixel_generator import sgpg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_W-1:0]    req_column,
   input  logic [COORD_W-1:0]    req_row,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CH_W-1:0]       rsp_red,
   output logic [CH_W-1:0]       rsp_green,
   output logic [CH_W-1:0]       rsp_blue,
   output logic [CH_W-1:0]       rsp_alpha,
   output logic [OFFSET_W-1:0]   rsp_byte_offset,
   output logic                  rsp_inside_res,
   output logic                  rsp_frame_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int LIN_W = COORD_W + DIM_W + 1;
   localparam logic [CH_W-1:0] BASE_CAP = 8'd128;
   localparam logic [CH_W-1:0] CH_MAX   = 8'hFF;

   // ---------------- configuration registers ----------------
   logic [3*CH_W-1:0]    bg_color_ff;
   logic [4*CH_W-1:0]    sky_color_ff;
   logic [DIM_W-1:0]     img_width_ff;
   logic [DIM_W-1:0]     img_height_ff;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 csr_we;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_we  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_color_ff   <= '0;
         sky_color_ff  <= '0;
         img_width_ff  <= DIM_W'(DIM_RESET);
         img_height_ff <= DIM_W'(DIM_RESET);
      end else if (csr_we) begin
         unique case (reg_idx)
            REG_BACKGROUND: bg_color_ff   <= pwdata[3*CH_W-1:0];
            REG_SKY:        sky_color_ff  <= pwdata[4*CH_W-1:0];
            REG_WIDTH:      img_width_ff  <= pwdata[DIM_W-1:0];
            REG_HEIGHT:     img_height_ff <= pwdata[DIM_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_BACKGROUND: prdata = CSR_DATA_W'(bg_color_ff);
         REG_SKY:        prdata = CSR_DATA_W'(sky_color_ff);
         REG_WIDTH:      prdata = CSR_DATA_W'(img_width_ff);
         REG_HEIGHT:     prdata = CSR_DATA_W'(img_height_ff);
      endcase
   end

   logic [DIM_W-1:0] w_eff, h_eff;
   assign w_eff = (img_width_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : img_width_ff;
   assign h_eff = (img_height_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : img_height_ff;

   // ---------------- derived settings, used from the divider on ----------------
   logic [CH_W-1:0] bg_r, bg_g, bg_b, sky_r, sky_g, sky_b, sky_a;
   logic [CH_W-1:0] bg_max, bv_raw, bv;
   logic [CH_W-1:0] base_r_in, base_g_in, base_b_in;
   logic [CH_W-1:0] base_r_ff, base_g_ff, base_b_ff;
   logic [COORD_W-1:0] dvs_in, dvs_ff;
   logic h_one_in, h_one_ff;

   assign bg_r  = bg_color_ff[3*CH_W-1:2*CH_W];
   assign bg_g  = bg_color_ff[2*CH_W-1:CH_W];
   assign bg_b  = bg_color_ff[CH_W-1:0];
   assign sky_r = sky_color_ff[4*CH_W-1:3*CH_W];
   assign sky_g = sky_color_ff[3*CH_W-1:2*CH_W];
   assign sky_b = sky_color_ff[2*CH_W-1:CH_W];
   assign sky_a = sky_color_ff[CH_W-1:0];

   always_comb begin
      bg_max = bg_r;
      if (bg_g > bg_max) begin
         bg_max = bg_g;
      end
      if (bg_b > bg_max) begin
         bg_max = bg_b;
      end
      bv_raw = CH_MAX - bg_max;
      bv     = (bv_raw > BASE_CAP) ? BASE_CAP : bv_raw;
   end

   assign base_r_in = (sky_r > bv) ? sky_r - bv : '0;
   assign base_g_in = (sky_g > bv) ? sky_g - bv : '0;
   assign base_b_in = (sky_b > bv) ? sky_b - bv : '0;
   // zero height wraps here; no row is inside then
   assign dvs_in    = COORD_W'(h_eff - DIM_W'(1));
   assign h_one_in  = (h_eff <= DIM_W'(1));

   always_ff @(posedge clock) begin
      base_r_ff <= base_r_in;
      base_g_ff <= base_g_in;
      base_b_ff <= base_b_in;
      dvs_ff    <= dvs_in;
      h_one_ff  <= h_one_in;
   end

   // ---------------- entry stage: bounds, last pixel, byte offset ----------------
   logic [LIN_W-1:0]  lin;
   side_type          ent_side_in, ent_side_ff;
   logic [COORD_W-1:0] ent_row_ff;
   logic              ent_vld_ff;
   logic              ent_adv;
   logic              div_in_ready;

   always_comb begin
      lin = LIN_W'(req_row) * LIN_W'(w_eff) + LIN_W'(req_column);
      ent_side_in.offset   = {lin[OFFSET_W-3:0], 2'b00};
      ent_side_in.in_frame = ({1'b0, req_column} < w_eff) && ({1'b0, req_row} < h_eff);
      ent_side_in.last     = ent_side_in.in_frame
                             && ({1'b0, req_column} == w_eff - DIM_W'(1))
                             && ({1'b0, req_row} == h_eff - DIM_W'(1));
   end

   assign ent_adv   = !ent_vld_ff || div_in_ready;
   assign req_ready = ent_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= 1'b0;
      end else if (ent_adv) begin
         ent_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_adv) begin
         ent_row_ff  <= req_row;
         ent_side_ff <= ent_side_in;
      end
   end

   // ---------------- divider and shading pipeline ----------------
   logic           div_out_valid, sh_in_ready;
   logic [V_W-1:0] div_v, sh_v;
   side_type       div_side, sh_side;
   shade_cfg_type  sh_cfg;

   sgpg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ent_vld_ff),
      .in_ready  (div_in_ready),
      .in_row    (ent_row_ff),
      .in_side   (ent_side_ff),
      .dvs       (dvs_ff),
      .out_valid (div_out_valid),
      .out_ready (sh_in_ready),
      .out_v     (div_v),
      .out_side  (div_side)
   );

   // single-row bitmap sits at the top of the gradient
   assign sh_v = h_one_ff ? '0 : div_v;

   assign sh_cfg.base_r = base_r_ff;
   assign sh_cfg.base_g = base_g_ff;
   assign sh_cfg.base_b = base_b_ff;
   assign sh_cfg.bg_r   = bg_r;
   assign sh_cfg.bg_g   = bg_g;
   assign sh_cfg.bg_b   = bg_b;
   assign sh_cfg.sky_a  = sky_a;

   sgpg_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_out_valid),
      .in_ready  (sh_in_ready),
      .in_v      (sh_v),
      .in_side   (div_side),
      .cfg       (sh_cfg),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue),
      .out_alpha (rsp_alpha),
      .out_side  (sh_side)
   );

   assign rsp_byte_offset = sh_side.offset;
   assign rsp_inside_res  = sh_side.in_frame;
   assign rsp_frame_last  = sh_side.last;

   // ---------------- assertions ----------------
   `SGPG_ASSERT_NOW(a_last_inside, rsp_valid && rsp_frame_last, rsp_inside_res,
      "frame_last beat outside the frame")
   `SGPG_ASSERT_NOW(a_outside_black, rsp_valid && !rsp_inside_res,
      rsp_red == '0 && rsp_green == '0 && rsp_blue == '0 && rsp_alpha == '0,
      "outside pixel carries color")
   `SGPG_ASSERT_NOW(a_one_row_clear, rsp_valid && rsp_inside_res && h_one_ff,
      rsp_red == '0 && rsp_green == '0 && rsp_blue == '0 && rsp_alpha == '0,
      "single-row bitmap pixel not transparent")
   `SGPG_ASSERT_NEXT(a_entry_hold, ent_vld_ff && !div_in_ready, ent_vld_ff,
      "entry beat dropped while divider stalled")

endmodule
